// File: rtl/core/crossbar_weight_mac_core_defines.svh
// assertion macros for the crossbar weight mac core
`ifndef CROSSBAR_WEIGHT_MAC_CORE_DEFINES_SVH
`define CROSSBAR_WEIGHT_MAC_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define CWM_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
	else $error("assertion failed");
`define CWM_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("assertion failed");
`else
`define CWM_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define CWM_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// File: rtl/core/cwm_pkg.sv
// shared types and constants of the crossbar weight mac core
package cwm_pkg;
	localparam int MAX_OUT   = 16;
	localparam int DRAIN_CYC = 20;
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_VEC   = 2'd1;
	localparam logic [1:0] OP_MASK  = 2'd2;
	localparam logic [1:0] OP_BCAST = 2'd3;
	localparam logic KIND_ROW = 1'b0;
	localparam logic KIND_COL = 1'b1;
	localparam logic [1:0] CFG_SIGNED = 2'd0;
	localparam logic [1:0] CFG_ROWS   = 2'd1;
	localparam logic [1:0] CFG_COLS   = 2'd2;

	typedef struct packed {
		logic               valid;
		logic               kind;
		logic [3:0]         tag;
		logic signed [32:0] value;
	} token_t;

	typedef struct packed {
		logic row;
		logic col;
	} clr_t;
endpackage

// File: rtl/core/cwm_wmem.sv
// weight pair memory with per-entry valid bits, registered read
module cwm_wmem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic signed [15:0]   wpos,
	input  logic signed [15:0]   wneg,
	input  logic [AW-1:0]        raddr,
	output logic signed [15:0]   rpos,
	output logic signed [15:0]   rneg
);
	logic [31:0]      mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= {wpos, wneg};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk) begin
		if (vld_q[raddr]) begin
			{rpos, rneg} <= mem_q[raddr];
		end else begin
			{rpos, rneg} <= '0;
		end
	end
endmodule

// File: rtl/core/cwm_cell.sv
// one accumulator cell: holds a row sum and a column sum, passes the token on
module cwm_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cwm_pkg::token_t       tok_in,
	input  cwm_pkg::clr_t         clr,
	output cwm_pkg::token_t       tok_out,
	output logic signed [47:0]    row_acc,
	output logic signed [47:0]    col_acc
);
	logic               hit;
	logic signed [47:0] base;
	logic signed [48:0] sum;
	logic signed [47:0] sat;

	assign hit  = tok_in.valid && (tok_in.tag == 4'(CELL_IDX));
	assign base = (tok_in.kind == cwm_pkg::KIND_ROW) ? row_acc : col_acc;

	always_comb begin
		sum = {base[47], base} + 49'(tok_in.value);
		if (sum[48] != sum[47]) begin
			sat = sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		end else begin
			sat = sum[47:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
			row_acc <= '0;
			col_acc <= '0;
		end else begin
			tok_out <= tok_in;
			if (clr.row) begin
				row_acc <= '0;
			end else if (hit && tok_in.kind == cwm_pkg::KIND_ROW) begin
				row_acc <= sat;
			end
			if (clr.col) begin
				col_acc <= '0;
			end else if (hit && tok_in.kind == cwm_pkg::KIND_COL) begin
				col_acc <= sat;
			end
		end
	end
endmodule

// File: rtl/core/crossbar_weight_mac_core.sv
// crossbar weight mac core: weight store, walk sequencer, accumulator cell chain
// write transaction: written in its accept cycle, no result
// compute transaction: accepted, then walked with one memory read per index below n,
// n = active rows or columns; then a drain lets the last product pass the 16-cell chain
// last transaction then emits n results, one per cycle while out_ready is high
// reset clears weight valid bits and all accumulators at once; no clearing pass
`include "crossbar_weight_mac_core_defines.svh"
module crossbar_weight_mac_core #(
	parameter int ROWS = 16,
	parameter int COLS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [4:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic [3:0]         row_index,
	input  logic [3:0]         col_index,
	input  logic signed [15:0] pos_weight,
	input  logic signed [15:0] neg_weight,
	input  logic signed [15:0] element_value,
	input  logic [15:0]        activation_mask,
	input  logic               broadcast_bit,
	input  logic               last_item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               result_kind,
	output logic [3:0]         result_index,
	output logic signed [47:0] sum_value,
	output logic               last_result
);
	localparam int ER    = (ROWS < cwm_pkg::MAX_OUT) ? ROWS : cwm_pkg::MAX_OUT;
	localparam int EC    = (COLS < cwm_pkg::MAX_OUT) ? COLS : cwm_pkg::MAX_OUT;
	localparam int DEPTH = ER * EC;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_WALK  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t             state_q;
	logic               smode_q;
	logic [4:0]         rows_q, cols_q;
	logic [4:0]         nr, nc, nwalk;
	logic [1:0]         op_q;
	logic [3:0]         r_q, c_q;
	logic signed [15:0] x_q;
	logic [15:0]        mask_q;
	logic               bc_q, last_q;
	logic [3:0]         k_q;
	logic [4:0]         drain_q;
	logic [3:0]         e_q;
	logic               accept, mem_we, walk_en, out_load, e_last;
	logic [AW-1:0]      waddr, raddr;
	logic signed [15:0] rpos, rneg;
	logic               en_s1, kind_s1;
	logic [3:0]         tag_s1;
	logic signed [16:0] w_s1;
	cwm_pkg::token_t    tok_s2;
	cwm_pkg::token_t    chain [cwm_pkg::MAX_OUT+1];
	cwm_pkg::clr_t      clr;
	logic signed [47:0] row_acc [cwm_pkg::MAX_OUT];
	logic signed [47:0] col_acc [cwm_pkg::MAX_OUT];

	// active sizes: zero counts as one, clipped to the built size
	always_comb begin
		nr = (rows_q == 5'd0) ? 5'd1 : rows_q;
		if (nr > 5'(ER)) nr = 5'(ER);
		nc = (cols_q == 5'd0) ? 5'd1 : cols_q;
		if (nc > 5'(EC)) nc = 5'(EC);
	end

	assign nwalk    = (op_q == cwm_pkg::OP_VEC) ? nr : nc;
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign mem_we   = accept && (opcode == cwm_pkg::OP_WRITE) &&
	                  ({1'b0, row_index} < nr) && ({1'b0, col_index} < nc);
	assign waddr    = AW'(32'(row_index) * EC + 32'(col_index));
	assign raddr    = (op_q == cwm_pkg::OP_VEC) ? AW'(32'(k_q) * EC + 32'(c_q))
	                                           : AW'(32'(r_q) * EC + 32'(k_q));

	always_comb begin
		if (op_q == cwm_pkg::OP_VEC) begin
			walk_en = ({1'b0, c_q} < nc);
		end else begin
			walk_en = ({1'b0, r_q} < nr) &&
			          ((op_q == cwm_pkg::OP_MASK) ? mask_q[k_q] : bc_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smode_q <= 1'b0;
			rows_q  <= 5'd16;
			cols_q  <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				cwm_pkg::CFG_SIGNED: smode_q <= cfg_data[0];
				cwm_pkg::CFG_ROWS:   rows_q  <= cfg_data;
				cwm_pkg::CFG_COLS:   cols_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			r_q    <= row_index;
			c_q    <= col_index;
			x_q    <= element_value;
			mask_q <= activation_mask;
			bc_q   <= broadcast_bit;
			last_q <= last_item;
		end
	end

	cwm_wmem #(.DEPTH(DEPTH), .AW(AW)) u_wmem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (waddr),
		.wpos   (pos_weight),
		.wneg   (neg_weight),
		.raddr  (raddr),
		.rpos   (rpos),
		.rneg   (rneg)
	);

	assign e_last   = ({1'b0, e_q} == nwalk - 5'd1);
	assign out_load = (state_q == ST_EMIT) && (!out_valid || out_ready);
	assign clr.row  = out_load && e_last && (op_q == cwm_pkg::OP_VEC);
	assign clr.col  = out_load && e_last && (op_q != cwm_pkg::OP_VEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			drain_q <= '0;
			e_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (accept && opcode != cwm_pkg::OP_WRITE) state_q <= ST_WALK;
				end
				ST_WALK: begin
					k_q <= k_q + 4'd1;
					if ({1'b0, k_q} == nwalk - 5'd1) begin
						drain_q <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 5'd1;
					if (drain_q == 5'(cwm_pkg::DRAIN_CYC - 1)) begin
						e_q     <= '0;
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						e_q <= e_q + 4'd1;
						if (e_last) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= (op_q == cwm_pkg::OP_VEC) ? cwm_pkg::KIND_ROW : cwm_pkg::KIND_COL;
		tag_s1  <= k_q;
	end

	assign w_s1 = 17'(rpos) - (smode_q ? 17'(rneg) : 17'sd0);

	// pipeline: memory read, then weight and product into the chain head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1  <= 1'b0;
			tok_s2 <= '0;
		end else begin
			en_s1        <= (state_q == ST_WALK) && walk_en;
			tok_s2.valid <= en_s1;
			tok_s2.kind  <= kind_s1;
			tok_s2.tag   <= tag_s1;
			if (kind_s1 == cwm_pkg::KIND_ROW) begin
				tok_s2.value <= 33'(w_s1 * x_q);
			end else begin
				tok_s2.value <= 33'(w_s1);
			end
		end
	end

	assign chain[0] = tok_s2;

	for (genvar g = 0; g < cwm_pkg::MAX_OUT; g++) begin : g_cell
		cwm_cell #(.CELL_IDX(g)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (chain[g]),
			.clr     (clr),
			.tok_out (chain[g+1]),
			.row_acc (row_acc[g]),
			.col_acc (col_acc[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_kind  <= (op_q == cwm_pkg::OP_VEC) ? cwm_pkg::KIND_ROW : cwm_pkg::KIND_COL;
			result_index <= e_q;
			sum_value    <= (op_q == cwm_pkg::OP_VEC) ? row_acc[e_q] : col_acc[e_q];
			last_result  <= e_last;
		end
	end

	`CWM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`CWM_ASSERT_IMPLY(a_no_token_idle, clk, arst_n, tok_s2.valid, state_q != ST_IDLE)
	`CWM_ASSERT_IMPLY(a_write_idle, clk, arst_n, mem_we, state_q == ST_IDLE)
endmodule

// File: tb/crossbar_weight_mac_core_checker.sv
// checker for the crossbar weight mac core: predicts sums and compares results
`timescale 1ns / 1ps
module crossbar_weight_mac_core_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [4:0]         cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic [3:0]         row_index,
	input  logic [3:0]         col_index,
	input  logic signed [15:0] pos_weight,
	input  logic signed [15:0] neg_weight,
	input  logic signed [15:0] element_value,
	input  logic [15:0]        activation_mask,
	input  logic               broadcast_bit,
	input  logic               last_item,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               result_kind,
	input  logic [3:0]         result_index,
	input  logic signed [47:0] sum_value,
	input  logic               last_result,
	output int                 fail_count,
	output int                 pending_sums
);
	typedef struct packed {
		logic               kind;
		logic [3:0]         index;
		logic signed [47:0] value;
		logic               last;
	} sum_t;

	localparam logic signed [63:0] SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

	logic signed [15:0] pos_mem [256];
	logic signed [15:0] neg_mem [256];
	logic signed [63:0] row_acc [16];
	logic signed [63:0] col_acc [16];
	logic               mode_signed;
	logic [4:0]         rows_cfg, cols_cfg;
	sum_t               sum_queue [$];

	assign pending_sums = sum_queue.size();

	function automatic int active_size(logic [4:0] v);
		if (v == 0)
			return 1;
		return (v > 16) ? 16 : int'(v);
	endfunction

	function automatic logic signed [63:0] sat48(logic signed [63:0] s);
		if (s > SAT_HI)
			return SAT_HI;
		if (s < SAT_LO)
			return SAT_LO;
		return s;
	endfunction

	function automatic logic signed [63:0] weight_of(int r, int c);
		logic signed [63:0] w;
		w = pos_mem[r*16+c];
		if (mode_signed)
			w = w - neg_mem[r*16+c];
		return w;
	endfunction

	task automatic predict_transaction();
		int   nr, nc;
		sum_t s;
		nr = active_size(rows_cfg);
		nc = active_size(cols_cfg);
		case (opcode)
			cwm_pkg::OP_WRITE: begin
				if (row_index < nr && col_index < nc) begin
					pos_mem[row_index*16+col_index] = pos_weight;
					neg_mem[row_index*16+col_index] = neg_weight;
				end
			end
			cwm_pkg::OP_VEC: begin
				if (col_index < nc)
					for (int i = 0; i < nr; i++)
						row_acc[i] = sat48(row_acc[i] + weight_of(i, col_index) * element_value);
				if (last_item) begin
					for (int i = 0; i < nr; i++) begin
						s = '{cwm_pkg::KIND_ROW, i[3:0], row_acc[i][47:0], i == nr - 1};
						sum_queue.push_back(s);
					end
					foreach (row_acc[i]) row_acc[i] = '0;
				end
			end
			default: begin
				if (row_index < nr)
					for (int j = 0; j < nc; j++)
						if ((opcode == cwm_pkg::OP_MASK) ? activation_mask[j] : broadcast_bit)
							col_acc[j] = sat48(col_acc[j] + weight_of(row_index, j));
				if (last_item) begin
					for (int j = 0; j < nc; j++) begin
						s = '{cwm_pkg::KIND_COL, j[3:0], col_acc[j][47:0], j == nc - 1};
						sum_queue.push_back(s);
					end
					foreach (col_acc[j]) col_acc[j] = '0;
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		sum_t e;
		if (!arst_n) begin
			foreach (pos_mem[k]) begin
				pos_mem[k] = '0;
				neg_mem[k] = '0;
			end
			foreach (row_acc[k]) begin
				row_acc[k] = '0;
				col_acc[k] = '0;
			end
			mode_signed = 1'b0;
			rows_cfg    = 5'd16;
			cols_cfg    = 5'd16;
			fail_count  = 0;
			sum_queue.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					cwm_pkg::CFG_SIGNED: mode_signed = cfg_data[0];
					cwm_pkg::CFG_ROWS:   rows_cfg = cfg_data;
					cwm_pkg::CFG_COLS:   cols_cfg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_transaction();
			if (out_valid && out_ready) begin
				if (sum_queue.size() == 0) begin
					$error("unexpected result transaction index %0d", result_index);
					fail_count++;
				end else begin
					e = sum_queue.pop_front();
					if (result_kind !== e.kind) begin
						$error("result_kind expected %0d actual %0d", e.kind, result_kind);
						fail_count++;
					end
					if (result_index !== e.index) begin
						$error("result_index expected %0d actual %0d", e.index, result_index);
						fail_count++;
					end
					if (sum_value !== e.value) begin
						$error("sum_value expected %0d actual %0d", e.value, sum_value);
						fail_count++;
					end
					if (last_result !== e.last) begin
						$error("last_result expected %0d actual %0d", e.last, last_result);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

// File: tb/crossbar_weight_mac_core_test.sv
// top of the crossbar weight mac core testbench: stimulus and verdict
`timescale 1ns / 1ps
module crossbar_weight_mac_core_test;
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = cwm_pkg::CFG_SIGNED;
	logic [4:0]         cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         opcode = cwm_pkg::OP_WRITE;
	logic [3:0]         row_index = '0;
	logic [3:0]         col_index = '0;
	logic signed [15:0] pos_weight = '0;
	logic signed [15:0] neg_weight = '0;
	logic signed [15:0] element_value = '0;
	logic [15:0]        activation_mask = '0;
	logic               broadcast_bit = 1'b0;
	logic               last_item = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               result_kind;
	logic [3:0]         result_index;
	logic signed [47:0] sum_value;
	logic               last_result;
	int                 fail_count;
	int                 pending_sums;
	logic               hold_off = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	crossbar_weight_mac_core dut (.*);
	crossbar_weight_mac_core_checker checker_i (.*);

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
	endfunction

	function automatic logic signed [15:0] rand_q();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [4:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_item(logic [1:0] op, logic [3:0] r, logic [3:0] c,
			logic signed [15:0] pw, logic signed [15:0] nw, logic signed [15:0] x,
			logic [15:0] m, logic b, logic l, bit no_gap);
		int g;
		g = no_gap ? 0 : gap_len();
		repeat (g) @(negedge clk);
		in_valid        <= 1'b1;
		opcode          <= op;
		row_index       <= r;
		col_index       <= c;
		pos_weight      <= pw;
		neg_weight      <= nw;
		element_value   <= x;
		activation_mask <= m;
		broadcast_bit   <= b;
		last_item       <= l;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic random_item(bit well_formed);
		logic [1:0] op;
		op = 2'($urandom);
		if (well_formed && $urandom_range(0, 2) == 0)
			op = cwm_pkg::OP_WRITE;
		send_item(op, 4'($urandom), 4'($urandom), rand_q(), rand_q(), rand_q(),
			16'($urandom), 1'($urandom), $urandom_range(0, 4) == 0, 1'b0);
	endtask

	task automatic settle();
		while (pending_sums != 0) @(negedge clk);
		repeat (cwm_pkg::DRAIN_CYC + 40) @(negedge clk);
	endtask

	// receiver: random stalls, or a long hold-off when asked
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				for (n = 0; n < 400; n++) @(negedge clk);
				hold_off = 1'b0;
			end
			if ($urandom_range(0, 15) == 0) begin
				out_ready <= 1'b0;
				repeat (gap_len()) @(negedge clk);
			end else begin
				out_ready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed: extreme weights, every opcode, out-of-range and last on write
		send_item(cwm_pkg::OP_WRITE, 0, 0, 16'sh7FFF, 16'sh8000, 0, 0, 0, 1, 1'b0);
		send_item(cwm_pkg::OP_WRITE, 15, 15, 16'sh8000, 16'sh7FFF, 0, 0, 0, 0, 1'b0);
		send_item(cwm_pkg::OP_WRITE, 3, 7, 16'sh1000, 16'sh0800, 0, 0, 0, 0, 1'b0);
		send_item(cwm_pkg::OP_VEC, 0, 0, 0, 0, 16'sh7FFF, 0, 0, 0, 1'b0);
		send_item(cwm_pkg::OP_VEC, 0, 15, 0, 0, 16'sh8000, 0, 0, 1, 1'b0);
		send_item(cwm_pkg::OP_MASK, 0, 0, 0, 0, 0, 16'hFFFF, 0, 0, 1'b0);
		send_item(cwm_pkg::OP_BCAST, 15, 0, 0, 0, 0, 0, 1, 1, 1'b0);
		send_item(cwm_pkg::OP_BCAST, 3, 0, 0, 0, 0, 0, 0, 1, 1'b0);
		settle();
		write_reg(cwm_pkg::CFG_SIGNED, 5'd1);
		write_reg(cwm_pkg::CFG_ROWS, 5'd4);
		write_reg(cwm_pkg::CFG_COLS, 5'd8);
		send_item(cwm_pkg::OP_WRITE, 5, 1, 16'sh7FFF, 0, 0, 0, 0, 0, 1'b0);
		send_item(cwm_pkg::OP_VEC, 0, 9, 0, 0, 16'sh7FFF, 0, 0, 1, 1'b0);
		send_item(cwm_pkg::OP_MASK, 3, 0, 0, 0, 0, 16'hFF00, 0, 0, 1'b0);
		send_item(cwm_pkg::OP_MASK, 0, 0, 0, 0, 0, 16'h00A5, 0, 1, 1'b0);
		send_item(cwm_pkg::OP_MASK, 9, 0, 0, 0, 0, 16'hFFFF, 0, 1, 1'b0);
		settle();
		write_reg(cwm_pkg::CFG_ROWS, 5'd0);
		write_reg(cwm_pkg::CFG_COLS, 5'd31);
		send_item(cwm_pkg::OP_VEC, 0, 3, 0, 0, 16'sh4000, 0, 0, 1, 1'b0);
		send_item(cwm_pkg::OP_BCAST, 0, 0, 0, 0, 0, 0, 1, 1, 1'b0);
		settle();
		// random phases across settings, extremes included
		for (int p = 0; p < 5; p++) begin
			write_reg(cwm_pkg::CFG_SIGNED, 5'($urandom_range(0, 1)));
			write_reg(cwm_pkg::CFG_ROWS, (p == 0) ? 5'd16 : (p == 1) ? 5'd1 : 5'($urandom));
			write_reg(cwm_pkg::CFG_COLS, (p == 0) ? 5'd16 : (p == 1) ? 5'd1 : 5'($urandom));
			if (p == 2)
				hold_off = 1'b1;
			for (int k = 0; k < 40; k++)
				random_item($urandom_range(0, 9) != 0);
			send_item(cwm_pkg::OP_BCAST, 0, 0, 0, 0, 0, 0, 1, 1, 1'b0);
			send_item(cwm_pkg::OP_VEC, 0, 0, 0, 0, 16'sh0100, 0, 0, 1, 1'b0);
			settle();
		end
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
